>>> design/gbfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_pkg: shared types and codes
// Word formats, item codes and register indexes of the grid search block.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] src_row;
    logic [7:0] src_col;
    logic [7:0] dest_row;
    logic [7:0] dest_col;
  } in_word_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        reachable;
  } out_word_t;

  // One entry of the cell memory.
  typedef struct packed {
    logic        blocked;
    logic        visited;
    logic [15:0] steps;
  } cell_t;

endpackage
`default_nettype wire

>>> design/grid_bfs_shortest_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path: shortest path on a blocked-cell grid
// Holds a map of blocked cells and answers distance queries by a
// breadth-first search that runs out of two on-chip memories.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word        Meaning
//  in_      input      in_word_t   clear map, mark a cell blocked, or query
//  out_     output     out_word_t  distance and reachable flag of a query
//  cfg_     input      index,data  grid_rows (index 0), grid_cols (index 1)
//
// With N = 2**(2*clog2(MAX_DIM)) cells, reset starts a clearing pass through
// all N entries of the cell memory during which no input word is accepted.
// A clear item sweeps all N entries likewise, a mark item writes one cell. A
// query sweeps the visited marks of all N cells, then for each cell it reaches
// reads the queue and the cell, then reads and checks each of its neighbours
// inside the grid, all bound by the single read port of the cell memory.
// The result word is held in an output register; a stalled result only
// holds up the next query once it is finished. Configuration words are
// taken in every cycle.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path
  import gbfs_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_index,
  input  wire logic [8:0] cfg_data
);

  localparam int CW = $clog2(MAX_DIM);   // bits of one coordinate
  localparam int AW = 2 * CW;            // bits of a cell address
  localparam int TW = AW + 1;            // queue pointers reach the full count
  localparam int GW = CW + 1;            // grid size register width
  localparam int VW = (GW > 9) ? GW : 9; // common width for compares

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLRMAP, S_VCLR, S_VCLR_END, S_SRC_RD, S_SRC_WR,
    S_POP, S_UREAD, S_UDIST, S_NB, S_CHK, S_DRES, S_OUT
  } state_t;

  function automatic logic [GW-1:0] clamp_dim(input logic [8:0] v);
    logic [GW-1:0] res;
    if (v == 9'd0) begin
      res = GW'(1);
    end else if (VW'(v) > VW'(MAX_DIM)) begin
      res = GW'(MAX_DIM);
    end else begin
      res = GW'(v);
    end
    return res;
  endfunction

  state_t         state_r;
  logic [GW-1:0]  rows_r, cols_r;
  logic [AW-1:0]  cnt_r;
  logic           sw_pend_r;
  logic [AW-1:0]  sw_addr_r;
  logic [TW-1:0]  head_r, tail_r;
  logic [AW-1:0]  u_r, v_r;
  logic [15:0]    du_r;
  logic [1:0]     k_r;
  logic [CW-1:0]  sr_r, sc_r, dr_r, dc_r;
  logic [15:0]    res_dist_r;
  logic           res_reach_r;
  logic           out_valid_r;
  out_word_t      out_r;

  // Memory ports.
  logic           st_we;
  logic [AW-1:0]  st_waddr, st_raddr;
  cell_t          st_wdata, st_rdata;
  logic [$bits(cell_t)-1:0] st_rvec;
  logic           q_we;
  logic [AW-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

  assign st_rdata = cell_t'(st_rvec);

  gbfs_ram #(.W($bits(cell_t)), .AW(AW)) u_cell_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rvec)
  );

  gbfs_ram #(.W(AW), .AW(AW)) u_queue_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  logic in_acc;
  logic src_in, dst_in;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign src_in = (VW'(in_data.src_row) < VW'(rows_r)) &&
                  (VW'(in_data.src_col) < VW'(cols_r));
  assign dst_in = (VW'(in_data.dest_row) < VW'(rows_r)) &&
                  (VW'(in_data.dest_col) < VW'(cols_r));

  // Neighbor of the cell being expanded, in the order up, down, left, right.
  logic [CW-1:0] ur, uc, vr, vc;
  logic          nb_ok;
  logic [15:0]   dinc;
  assign ur   = u_r[AW-1:CW];
  assign uc   = u_r[CW-1:0];
  assign dinc = (du_r == 16'hFFFF) ? du_r : du_r + 16'd1;

  always_comb begin
    vr    = ur;
    vc    = uc;
    nb_ok = 1'b0;
    case (k_r)
      2'd0: begin
        nb_ok = (ur != '0);
        vr    = ur - CW'(1);
      end
      2'd1: begin
        nb_ok = ((GW'(ur) + GW'(1)) < rows_r);
        vr    = ur + CW'(1);
      end
      2'd2: begin
        nb_ok = (uc != '0);
        vc    = uc - CW'(1);
      end
      default: begin
        nb_ok = ((GW'(uc) + GW'(1)) < cols_r);
        vc    = uc + CW'(1);
      end
    endcase
  end

  logic cell_free;
  assign cell_free = !st_rdata.visited && !st_rdata.blocked;

  // Memory port control follows the current state.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cnt_r;
    st_wdata = '0;
    st_raddr = cnt_r;
    q_we     = 1'b0;
    q_waddr  = tail_r[AW-1:0];
    q_wdata  = v_r;
    q_raddr  = head_r[AW-1:0];
    unique case (state_r)
      S_INIT, S_CLRMAP: begin
        st_we = 1'b1;
      end
      S_IDLE: begin
        st_waddr = {CW'(in_data.src_row), CW'(in_data.src_col)};
        st_wdata = '{blocked: 1'b1, visited: 1'b0, steps: 16'd0};
        st_we    = in_acc && (in_data.func == FUNC_MARK) && src_in;
      end
      S_VCLR, S_VCLR_END: begin
        st_we    = sw_pend_r;
        st_waddr = sw_addr_r;
        st_wdata = '{blocked: st_rdata.blocked, visited: 1'b0, steps: st_rdata.steps};
      end
      S_SRC_RD: begin
        st_raddr = {sr_r, sc_r};
      end
      S_SRC_WR: begin
        st_we    = 1'b1;
        st_waddr = {sr_r, sc_r};
        st_wdata = '{blocked: st_rdata.blocked, visited: 1'b1, steps: 16'd0};
        q_we     = 1'b1;
        q_waddr  = '0;
        q_wdata  = {sr_r, sc_r};
      end
      S_POP: begin
        st_raddr = {dr_r, dc_r};
      end
      S_UREAD: begin
        st_raddr = q_rdata;
      end
      S_NB: begin
        st_raddr = {vr, vc};
      end
      S_CHK: begin
        st_we    = cell_free;
        st_waddr = v_r;
        st_wdata = '{blocked: 1'b0, visited: 1'b1, steps: dinc};
        q_we     = cell_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      rows_r      <= clamp_dim(9'd256);
      cols_r      <= clamp_dim(9'd256);
      cnt_r       <= '0;
      sw_pend_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS) begin
          rows_r <= clamp_dim(cfg_data);
        end else begin
          cols_r <= clamp_dim(cfg_data);
        end
      end
      // In S_OUT the output register is reloaded by the state machine itself.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT, S_CLRMAP: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            sr_r        <= CW'(in_data.src_row);
            sc_r        <= CW'(in_data.src_col);
            dr_r        <= CW'(in_data.dest_row);
            dc_r        <= CW'(in_data.dest_col);
            cnt_r       <= '0;
            sw_pend_r   <= 1'b0;
            res_dist_r  <= 16'd0;
            res_reach_r <= 1'b0;
            case (in_data.func)
              FUNC_CLEAR: state_r <= S_CLRMAP;
              FUNC_QUERY: state_r <= (src_in && dst_in) ? S_VCLR : S_OUT;
              default:    state_r <= S_IDLE;
            endcase
          end
        end
        S_VCLR: begin
          sw_pend_r <= 1'b1;
          sw_addr_r <= cnt_r;
          cnt_r     <= cnt_r + AW'(1);
          if (cnt_r == '1) begin
            state_r <= S_VCLR_END;
          end
        end
        S_VCLR_END: begin
          state_r <= S_SRC_RD;
        end
        S_SRC_RD: begin
          state_r <= S_SRC_WR;
        end
        S_SRC_WR: begin
          head_r  <= '0;
          tail_r  <= TW'(1);
          state_r <= S_POP;
        end
        S_POP: begin
          if (head_r == tail_r) begin
            state_r <= S_DRES;
          end else begin
            head_r  <= head_r + TW'(1);
            state_r <= S_UREAD;
          end
        end
        S_UREAD: begin
          u_r     <= q_rdata;
          state_r <= S_UDIST;
        end
        S_UDIST: begin
          du_r    <= st_rdata.steps;
          k_r     <= '0;
          state_r <= S_NB;
        end
        S_NB: begin
          if (nb_ok) begin
            v_r     <= {vr, vc};
            state_r <= S_CHK;
          end else if (k_r == 2'd3) begin
            state_r <= S_POP;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_CHK: begin
          if (cell_free) begin
            tail_r <= tail_r + TW'(1);
          end
          if (k_r == 2'd3) begin
            state_r <= S_POP;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_NB;
          end
        end
        S_DRES: begin
          res_reach_r <= st_rdata.visited;
          res_dist_r  <= st_rdata.visited ? st_rdata.steps : 16'd0;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.distance  <= res_dist_r;
            out_r.reachable <= res_reach_r;
            out_valid_r     <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/gbfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbfs_ram #(
  parameter int W  = 18,
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> verif/grid_bfs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_bfs_checker: result predictor and scoreboard for the grid search block
// Watches the input, result and register channels. It keeps its own copy of
// the blocked map and the grid size and predicts each query's distance and
// reachable flag by its own breadth-first search.
// ----------------------------------------------------------------------------
module grid_bfs_checker
  import gbfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire in_word_t   in_data,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire out_word_t  out_data,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data,
  output int              pending,
  output int              mismatches,
  output int              results_seen
);

  localparam int DIM   = 256;
  localparam int CELLS = DIM * DIM;

  int        rows_used = DIM;
  int        cols_used = DIM;
  bit        wall_map[CELLS];
  int        step_count[CELLS];
  int        frontier[CELLS];
  out_word_t expected_dist[$];

  function automatic int clamp_size(logic [8:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  // Breadth-first search from the source; returns the word the block owes.
  function automatic out_word_t shortest_path(in_word_t w);
    out_word_t res;
    int head;
    int tail;
    int cur;
    int nr;
    int nc;
    int dr[4];
    int dc[4];
    res = '0;
    dr = '{-1, 1, 0, 0};
    dc = '{0, 0, -1, 1};
    if (w.src_row >= rows_used || w.src_col >= cols_used) return res;
    for (int r = 0; r < rows_used; r++)
      for (int c = 0; c < cols_used; c++) step_count[r * DIM + c] = -1;
    head = 0;
    tail = 1;
    frontier[0] = w.src_row * DIM + w.src_col;
    // The source counts as visited even when it is blocked.
    step_count[frontier[0]] = 0;
    while (head < tail) begin
      cur = frontier[head];
      head++;
      for (int k = 0; k < 4; k++) begin
        nr = cur / DIM + dr[k];
        nc = cur % DIM + dc[k];
        if (nr < 0 || nc < 0 || nr >= rows_used || nc >= cols_used) continue;
        if (step_count[nr * DIM + nc] >= 0 || wall_map[nr * DIM + nc]) continue;
        step_count[nr * DIM + nc] = step_count[cur] + 1;
        frontier[tail] = nr * DIM + nc;
        tail++;
      end
    end
    if (w.dest_row >= rows_used || w.dest_col >= cols_used) return res;
    cur = step_count[w.dest_row * DIM + w.dest_col];
    if (cur >= 0) begin
      res.distance  = (cur > 65535) ? 16'hFFFF : 16'(cur);
      res.reachable = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROWS) rows_used = clamp_size(cfg_data);
      else                       cols_used = clamp_size(cfg_data);
    end
    if (rst_n && in_valid && in_ready) begin
      case (in_data.func)
        FUNC_CLEAR: begin
          foreach (wall_map[i]) wall_map[i] = 1'b0;
        end
        FUNC_MARK: begin
          if (in_data.src_row < rows_used && in_data.src_col < cols_used)
            wall_map[in_data.src_row * DIM + in_data.src_col] = 1'b1;
        end
        FUNC_QUERY: begin
          expected_dist.push_back(shortest_path(in_data));
        end
        default: ;
      endcase
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_dist.size() == 0) begin
        $error("result word with no query waiting: distance %0d reachable %0d",
               out_data.distance, out_data.reachable);
        mismatches++;
      end else begin
        if (out_data.distance !== expected_dist[0].distance) begin
          $error("distance: expected %0d, actual %0d",
                 expected_dist[0].distance, out_data.distance);
          mismatches++;
        end
        if (out_data.reachable !== expected_dist[0].reachable) begin
          $error("reachable: expected %0d, actual %0d",
                 expected_dist[0].reachable, out_data.reachable);
          mismatches++;
        end
        void'(expected_dist.pop_front());
      end
    end
    pending <= expected_dist.size();
  end

  initial begin
    pending = 0;
    mismatches = 0;
    results_seen = 0;
  end

endmodule

>>> verif/tb_grid_bfs_shortest_path.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_bfs_shortest_path: testbench top for the grid search block
// Drives map edits, distance queries and grid size writes under several
// idling patterns, including one long result stall. The checker beside the
// block predicts every query and counts mismatches; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_grid_bfs_shortest_path;
  import gbfs_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  int pending;
  int mismatches;
  int results_seen;

  // Our own view of the grid in use, only for shaping the stimulus.
  int rows_now = 256;
  int cols_now = 256;
  int send_idle = 0;
  int recv_idle = 0;
  int words_sent = 0;
  int queries_sent = 0;

  // Long result stall: requested by the stimulus, counted by the receiver.
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always #6 clk = ~clk;

  grid_bfs_shortest_path dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  grid_bfs_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches), .results_seen(results_seen)
  );

  // The receiver drops ready at random, or for a long stretch once asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 200000;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one word, called from just after a rising clock. Valid is only
  // lowered when a gap is taken, so it never drops and rises at one time step.
  task automatic send_word(in_word_t w);
    int gap;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (w.func == FUNC_QUERY) queries_sent++;
  endtask

  task automatic send_fields(func_t f, int sr, int sc, int dr, int dc);
    in_word_t w;
    w.func = f;
    w.src_row = sr[7:0];
    w.src_col = sc[7:0];
    w.dest_row = dr[7:0];
    w.dest_col = dc[7:0];
    send_word(w);
  endtask

  // Waits for every result and until the block is idle again, which also
  // covers a clear still sweeping the memory.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !in_ready);
  endtask

  task automatic write_size(logic idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Mirror the block's clamping so random cells land inside the grid.
    if (idx == REG_ROWS) rows_now = (val == 0) ? 1 : (val > 256) ? 256 : val;
    else                 cols_now = (val == 0) ? 1 : (val > 256) ? 256 : val;
  endtask

  task automatic resize(int r, int c);
    write_size(REG_ROWS, 9'(r));
    write_size(REG_COLS, 9'(c));
  endtask

  // Mostly marks and queries inside the grid, with some out-of-grid cells,
  // clears and unused codes as noise.
  task automatic random_words(int count);
    in_word_t w;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      w = '0;
      w.src_row  = 8'($urandom_range(rows_now - 1));
      w.src_col  = 8'($urandom_range(cols_now - 1));
      w.dest_row = 8'($urandom_range(rows_now - 1));
      w.dest_col = 8'($urandom_range(cols_now - 1));
      if (pick < 45) begin
        w.func = FUNC_MARK;
      end else if (pick < 85) begin
        w.func = FUNC_QUERY;
      end else if (pick < 92) begin
        w.func = ($urandom_range(1)) ? FUNC_QUERY : FUNC_MARK;
        w.src_row  = 8'($urandom);
        w.dest_col = 8'($urandom);
      end else if (pick < 96) begin
        w.func = FUNC_CLEAR;
      end else begin
        w.func = FUNC_NONE;
        w.src_row = 8'($urandom);
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size 256 by 256: corner to corner on the open map.
    send_fields(FUNC_QUERY, 0, 0, 255, 255);
    drain();

    // One row of full width, written with zero rows and an oversized count.
    resize(0, 511);
    send_fields(FUNC_QUERY, 0, 255, 0, 0);
    send_fields(FUNC_MARK, 0, 100, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 0, 200);
    send_fields(FUNC_MARK, 255, 5, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 255, 255);
    send_fields(FUNC_QUERY, 255, 0, 0, 3);
    send_fields(FUNC_MARK, 0, 50, 0, 0);
    send_fields(FUNC_QUERY, 0, 50, 0, 50);
    send_fields(FUNC_QUERY, 0, 50, 0, 60);
    send_fields(FUNC_NONE, 255, 255, 255, 255);
    send_fields(FUNC_CLEAR, 0, 0, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 0, 200);
    drain();

    // One column of full height, then a walled-off corner on a 3 by 3 grid.
    resize(511, 1);
    send_fields(FUNC_QUERY, 255, 0, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 0, 255);
    drain();
    resize(3, 3);
    send_fields(FUNC_MARK, 0, 1, 0, 0);
    send_fields(FUNC_MARK, 1, 0, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 2, 2);
    send_fields(FUNC_QUERY, 2, 2, 0, 1);
    send_fields(FUNC_CLEAR, 0, 0, 0, 0);
    drain();

    // Random part, first with the receiver idling more.
    send_idle = 17;
    recv_idle = 49;
    resize($urandom_range(2, 8), $urandom_range(2, 12));
    random_words(35);
    drain();

    send_idle = 49;
    recv_idle = 17;
    resize($urandom_range(2, 12), $urandom_range(2, 8));
    random_words(35);
    drain();

    // No idling; a long result stall backs queries up into the input.
    send_idle = 0;
    recv_idle = 0;
    resize($urandom_range(2, 10), $urandom_range(2, 10));
    hold_request <= 1'b1;
    for (int i = 0; i < 4; i++)
      send_fields(FUNC_QUERY, 0, 0, rows_now - 1, cols_now - 1);
    random_words(30);
    drain();

    $display("Sent %0d words with %0d queries; %0d results checked.",
             words_sent, queries_sent, results_seen);
    $display("Grids ran from 1 cell wide up to 256 by 256, with idle and stall mixes.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #480_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
design/gbfs_pkg.sv
design/gbfs_ram.sv
design/grid_bfs_shortest_path.sv
verif/grid_bfs_checker.sv
verif/tb_grid_bfs_shortest_path.sv
